FILE: sv/priority_run_queue_scheduler_defines.svh
// assertion macros for the run queue scheduler
`ifndef PRIORITY_RUN_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_RUN_QUEUE_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
// checked property, quiet while reset is applied
`define PRQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("scheduler assertion failed");
// checked property, also watched through reset
`define PRQ_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("scheduler assertion failed");
`else
`define PRQ_ASSERT(lbl, clk, rstn, prop)
`define PRQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/prq_pkg.sv
// shared types and constants of the run queue scheduler
package prq_pkg;
	localparam int THREAD_SLOTS = 16;
	localparam int PRIO_LEVELS  = 16;
	localparam int IW = $clog2(THREAD_SLOTS);
	localparam int LW = $clog2(THREAD_SLOTS + 1);
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	localparam int PW = $clog2(PRIO_LEVELS);
	localparam int NORM_PRIO = (PRIO_LEVELS > 5) ? 5 : PRIO_LEVELS - 1;

	typedef enum logic [3:0] {
		CMD_START   = 4'd0,
		CMD_RESUME  = 4'd1,
		CMD_URESUME = 4'd2,
		CMD_USUSP   = 4'd3,
		CMD_YIELD   = 4'd4,
		CMD_KILL    = 4'd5,
		CMD_SETPRIO = 4'd6,
		CMD_RESCHED = 4'd7,
		CMD_QUERY   = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_RUN  = 2'd1,
		ST_SUSP = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_NOSLOT = 2'd1,
		ERR_NORUN  = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_ALLOC, S_ENQ1, S_ENQ2, S_URES, S_USUS,
		S_YCHK, S_UINIT, S_UWALK, S_UCLR, S_KILL, S_SETP, S_SCAN, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_DECODE, OP_QUERY, OP_FIND, OP_ALLOC, OP_ENQ1,
		OP_ENQ2, OP_URES, OP_USUS, OP_YCHK, OP_UINIT, OP_UWALK, OP_UCLR,
		OP_KILL, OP_SETP, OP_SCAN, OP_DONE
	} op_t;

	typedef struct packed {
		op_t  op;
		logic take_cur;
	} ctl_t;

	typedef struct packed {
		logic     valid;
		slot_st_t stat;
		logic     usus;
		logic     free_here;
		logic     find_last;
		logic     yld_ok;
		logic     hit;
		logic     walk_end;
		logic     is_cur;
		logic     scan_hit;
		logic     scan_zero;
	} sts_t;
endpackage

FILE: sv/prq_ctrl.sv
// command sequencer of the run queue scheduler
module prq_ctrl import prq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [3:0] cmd,
	input  sts_t       sts,
	output ctl_t       ctl,
	output logic       busy
);
	state_t state_q, state_d;
	cmd_t   cmd_q;

	// state and command registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_START;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				cmd_q <= cmd_t'(cmd);
			end
		end
	end

	// continuation once an unlink walk has ended
	function automatic state_t after_unlink(input cmd_t c, input logic found,
			input logic is_cur);
		state_t s;
		s = S_DONE;
		case (c)
			CMD_USUSP:   s = (found && is_cur) ? S_SCAN : S_DONE;
			CMD_YIELD:   s = found ? S_ENQ1 : S_DONE;
			CMD_KILL:    s = S_KILL;
			CMD_SETPRIO: s = S_SETP;
			default:     s = S_DONE;
		endcase
		return s;
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_DECODE;
			S_DECODE: begin
				case (cmd_q)
					CMD_START:   state_d = S_FIND;
					CMD_RESUME:  state_d = (sts.valid && sts.stat != ST_RUN) ? S_ENQ1 : S_DONE;
					CMD_URESUME: state_d = (sts.valid && sts.usus) ? S_URES : S_DONE;
					CMD_USUSP:   state_d = (sts.valid && sts.stat != ST_SUSP) ? S_USUS : S_DONE;
					CMD_YIELD:   state_d = S_YCHK;
					CMD_KILL:    state_d = !sts.valid ? S_DONE :
						(sts.stat == ST_RUN) ? S_UINIT : S_KILL;
					CMD_SETPRIO: state_d = !sts.valid ? S_DONE :
						(sts.stat == ST_SUSP) ? S_SETP : S_UINIT;
					CMD_RESCHED: state_d = S_SCAN;
					default:     state_d = S_DONE;
				endcase
			end
			S_FIND: begin
				if (sts.free_here) state_d = S_ALLOC;
				else if (sts.find_last) state_d = S_DONE;
			end
			S_ALLOC: state_d = S_ENQ1;
			S_ENQ1:  state_d = S_ENQ2;
			S_ENQ2:  state_d = S_DONE;
			S_URES:  state_d = (sts.stat != ST_RUN) ? S_ENQ1 : S_DONE;
			S_USUS:  state_d = S_UINIT;
			S_YCHK:  state_d = sts.yld_ok ? S_UINIT : S_DONE;
			S_UINIT: state_d = S_UWALK;
			S_UWALK: begin
				if (sts.hit) state_d = S_UCLR;
				else if (sts.walk_end) state_d = after_unlink(cmd_q, 1'b0, sts.is_cur);
			end
			S_UCLR: state_d = after_unlink(cmd_q, 1'b1, sts.is_cur);
			S_KILL: state_d = S_DONE;
			S_SETP: state_d = (sts.stat == ST_SUSP) ? S_DONE : S_ENQ1;
			S_SCAN: if (sts.scan_hit || sts.scan_zero) state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl.op       = OP_NONE;
		ctl.take_cur = (cmd_t'(cmd) == CMD_YIELD);
		case (state_q)
			S_IDLE:   ctl.op = start ? OP_ACCEPT : OP_NONE;
			S_DECODE: ctl.op = (cmd_q == CMD_QUERY) ? OP_QUERY : OP_DECODE;
			S_FIND:   ctl.op = OP_FIND;
			S_ALLOC:  ctl.op = OP_ALLOC;
			S_ENQ1:   ctl.op = OP_ENQ1;
			S_ENQ2:   ctl.op = OP_ENQ2;
			S_URES:   ctl.op = OP_URES;
			S_USUS:   ctl.op = OP_USUS;
			S_YCHK:   ctl.op = OP_YCHK;
			S_UINIT:  ctl.op = OP_UINIT;
			S_UWALK:  ctl.op = OP_UWALK;
			S_UCLR:   ctl.op = OP_UCLR;
			S_KILL:   ctl.op = OP_KILL;
			S_SETP:   ctl.op = OP_SETP;
			S_SCAN:   ctl.op = OP_SCAN;
			S_DONE:   ctl.op = OP_DONE;
			default:  ctl.op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

FILE: sv/prq_dp.sv
// slot tables, run queues and counters of the run queue scheduler
`include "priority_run_queue_scheduler_defines.svh"
module prq_dp import prq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_t       ctl,
	input  logic [3:0] thread,
	input  logic       use_current,
	input  logic [3:0] priority_req,
	input  logic       daemon,
	output sts_t       sts,
	output logic       done,
	output logic [3:0] slot,
	output logic [3:0] current,
	output logic       switched,
	output logic       need_resched,
	output logic       alive,
	output logic       only_daemons,
	output logic [1:0] error
);
	localparam logic [LW-1:0] NIL = LW'(THREAD_SLOTS);

	slot_st_t         stat_q [THREAD_SLOTS];
	logic [PW-1:0]    prio_q [THREAD_SLOTS];
	logic             dmn_q  [THREAD_SLOTS];
	logic             usus_q [THREAD_SLOTS];
	logic [LW-1:0]    next_q [THREAD_SLOTS];
	logic [LW-1:0]    head_q [PRIO_LEVELS];
	logic [LW-1:0]    tail_q [PRIO_LEVELS];

	logic [IW-1:0] tgt_q, find_q, cur_q, before_q, slot_res_q;
	logic          rng_q, dmn_in_q, resched_q, alive_q, only_q;
	logic [PW-1:0] prio_in_q, p_q, lvl_q;
	logic [LW-1:0] walk_q, prev_q;
	logic [CW-1:0] n_q, live_q, dcnt_q;
	err_t          err_q;

	logic          done_q, sw_q, rs_q, al_q, od_q;
	logic [IW-1:0] oslot_q, ocur_q;
	err_t          oerr_q;

	logic [IW-1:0] st_addr, pr_addr, walk_idx, prev_idx, tail_idx;
	logic [PW-1:0] hq_addr, prio_clamp;
	slot_st_t      st_rd;
	logic [PW-1:0] pr_rd;
	logic [LW-1:0] head_rd, tail_rd, nx_rd, tgt_link;
	logic          sel_cur, walk_end, hit;
	logic [CW-1:0] live_dec, dcnt_dec;

	// read ports, one address each
	assign st_addr  = (ctl.op == OP_FIND) ? find_q : tgt_q;
	assign pr_addr  = (ctl.op == OP_ENQ2) ? cur_q : tgt_q;
	assign hq_addr  = (ctl.op == OP_SCAN) ? lvl_q : p_q;
	assign walk_idx = walk_q[IW-1:0];
	assign prev_idx = prev_q[IW-1:0];
	assign st_rd    = stat_q[st_addr];
	assign pr_rd    = prio_q[pr_addr];
	assign head_rd  = head_q[hq_addr];
	assign tail_rd  = tail_q[hq_addr];
	assign tail_idx = tail_rd[IW-1:0];
	assign nx_rd    = next_q[walk_idx];
	assign tgt_link = LW'(tgt_q);

	// list walk and decode terms
	assign sel_cur    = ctl.take_cur | use_current;
	assign prio_clamp = (32'(priority_req) >= 32'(PRIO_LEVELS)) ?
		PW'(PRIO_LEVELS - 1) : PW'(priority_req);
	assign walk_end   = (walk_q >= NIL) || (n_q == CW'(THREAD_SLOTS));
	assign hit        = !walk_end && (walk_q == tgt_link);
	assign live_dec   = live_q - CW'(1);
	assign dcnt_dec   = dmn_q[tgt_q] ? dcnt_q - CW'(1) : dcnt_q;

	// status towards the sequencer
	always_comb begin
		sts.valid     = rng_q && (st_rd != ST_FREE);
		sts.stat      = st_rd;
		sts.usus      = usus_q[tgt_q];
		sts.free_here = (st_rd == ST_FREE);
		sts.find_last = (find_q == IW'(THREAD_SLOTS - 1));
		sts.yld_ok    = (st_rd == ST_RUN) && (head_rd != tail_rd);
		sts.hit       = hit;
		sts.walk_end  = walk_end;
		sts.is_cur    = (tgt_q == cur_q);
		sts.scan_hit  = (head_rd != NIL);
		sts.scan_zero = (lvl_q == '0);
	end

	// slot tables and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				stat_q[i] <= ST_FREE;
				prio_q[i] <= '0;
				dmn_q[i]  <= 1'b0;
				usus_q[i] <= 1'b0;
				next_q[i] <= NIL;
			end
			for (int j = 0; j < PRIO_LEVELS; j++) begin
				head_q[j] <= NIL;
				tail_q[j] <= NIL;
			end
			stat_q[0]         <= ST_RUN;
			prio_q[0]         <= PW'(NORM_PRIO);
			head_q[NORM_PRIO] <= '0;
			tail_q[NORM_PRIO] <= '0;
		end else begin
			case (ctl.op)
				OP_ALLOC: begin
					stat_q[find_q] <= ST_SUSP;
					prio_q[find_q] <= prio_in_q;
					dmn_q[find_q]  <= dmn_in_q;
					usus_q[find_q] <= 1'b0;
					next_q[find_q] <= NIL;
				end
				OP_ENQ1: next_q[tgt_q] <= NIL;
				OP_ENQ2: begin
					stat_q[tgt_q] <= ST_RUN;
					if (head_rd == NIL) begin
						head_q[p_q] <= tgt_link;
					end else begin
						next_q[tail_idx] <= tgt_link;
					end
					tail_q[p_q] <= tgt_link;
				end
				OP_URES: usus_q[tgt_q] <= 1'b0;
				OP_USUS: begin
					stat_q[tgt_q] <= ST_SUSP;
					usus_q[tgt_q] <= 1'b1;
				end
				OP_UWALK: begin
					if (hit) begin
						if (prev_q == NIL) begin
							head_q[p_q] <= nx_rd;
						end else begin
							next_q[prev_idx] <= nx_rd;
						end
						if (tail_rd == tgt_link) begin
							tail_q[p_q] <= prev_q;
						end
					end
				end
				OP_UCLR: next_q[tgt_q] <= NIL;
				OP_KILL: begin
					stat_q[tgt_q] <= ST_FREE;
					dmn_q[tgt_q]  <= 1'b0;
					usus_q[tgt_q] <= 1'b0;
					next_q[tgt_q] <= NIL;
				end
				OP_SETP: prio_q[tgt_q] <= prio_in_q;
				default: ;
			endcase
		end
	end

	// control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			resched_q <= 1'b0;
			live_q    <= CW'(1);
			dcnt_q    <= '0;
			lvl_q     <= PW'(PRIO_LEVELS - 1);
			tgt_q     <= '0;
			rng_q     <= 1'b0;
			find_q    <= '0;
			before_q  <= '0;
			p_q       <= '0;
			walk_q    <= NIL;
			prev_q    <= NIL;
			n_q       <= '0;
			prio_in_q <= '0;
			dmn_in_q  <= 1'b0;
			slot_res_q <= '0;
			err_q     <= ERR_OK;
			alive_q   <= 1'b0;
			only_q    <= 1'b0;
		end else begin
			if (ctl.op != OP_SCAN) begin
				lvl_q <= PW'(PRIO_LEVELS - 1);
			end
			case (ctl.op)
				OP_ACCEPT: begin
					tgt_q      <= sel_cur ? cur_q : IW'(thread);
					rng_q      <= sel_cur || (32'(thread) < 32'(THREAD_SLOTS));
					prio_in_q  <= prio_clamp;
					dmn_in_q   <= daemon;
					before_q   <= cur_q;
					find_q     <= '0;
					slot_res_q <= '0;
					err_q      <= ERR_OK;
					alive_q    <= 1'b0;
					only_q     <= 1'b0;
				end
				OP_DECODE: p_q <= pr_rd;
				OP_QUERY:  alive_q <= sts.valid;
				OP_FIND: begin
					if (st_rd != ST_FREE) begin
						if (sts.find_last) err_q <= ERR_NOSLOT;
						else find_q <= find_q + IW'(1);
					end
				end
				OP_ALLOC: begin
					tgt_q      <= find_q;
					slot_res_q <= find_q;
					live_q     <= live_q + CW'(1);
					dcnt_q     <= dcnt_q + CW'(dmn_in_q);
				end
				OP_ENQ1: p_q <= pr_rd;
				OP_ENQ2: begin
					if (head_rd == NIL && p_q > pr_rd) resched_q <= 1'b1;
				end
				OP_YCHK: if (sts.yld_ok) resched_q <= 1'b1;
				OP_UINIT: begin
					walk_q <= head_rd;
					prev_q <= NIL;
					n_q    <= '0;
				end
				OP_UWALK: begin
					if (!hit && !walk_end) begin
						prev_q <= walk_q;
						walk_q <= nx_rd;
						n_q    <= n_q + CW'(1);
					end
				end
				OP_KILL: begin
					live_q    <= live_dec;
					dcnt_q    <= dcnt_dec;
					only_q    <= (live_dec == dcnt_dec);
					resched_q <= 1'b1;
				end
				OP_SCAN: begin
					resched_q <= 1'b0;
					if (head_rd != NIL) begin
						cur_q <= head_rd[IW-1:0];
					end else if (lvl_q == '0) begin
						err_q <= ERR_NORUN;
					end else begin
						lvl_q <= lvl_q - PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result registers, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == OP_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_DONE) begin
			oslot_q <= slot_res_q;
			ocur_q  <= cur_q;
			sw_q    <= (cur_q != before_q);
			rs_q    <= resched_q;
			al_q    <= alive_q;
			od_q    <= only_q;
			oerr_q  <= err_q;
		end
	end

	assign done         = done_q;
	assign slot         = 4'(oslot_q);
	assign current      = 4'(ocur_q);
	assign switched     = sw_q;
	assign need_resched = rs_q;
	assign alive        = al_q;
	assign only_daemons = od_q;
	assign error        = oerr_q;

	// daemons are a subset of the live threads
	`PRQ_ASSERT(a_dcnt_le_live, clk, arst_n, dcnt_q <= live_q)
	// a finished transaction is shown in the next cycle
	`PRQ_ASSERT(a_done_follows, clk, arst_n, (ctl.op == OP_DONE) |=> done_q)
	// results never come back to back
	`PRQ_ASSERT(a_done_single, clk, arst_n, done_q |=> !done_q)
	// a queue is empty at both ends or at neither
	`PRQ_ASSERT_ALWAYS(a_head_tail, clk, (head_rd == NIL) == (tail_rd == NIL))
endmodule

FILE: sv/priority_run_queue_scheduler.sv
// top level of the priority run queue scheduler
// A command is taken when start is high while busy is low; busy then stays high
// until the command has finished, and its result appears for exactly one cycle
// with done high, in the first cycle in which busy is low again. The receiver cannot stall it.
// The free-slot search tests one slot a cycle, unlinking walks the run queue one
// link a cycle, and rescheduling scans the priority levels one a cycle from the top.
module priority_run_queue_scheduler import prq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [3:0] cmd,
	input  logic [3:0] thread,
	input  logic       use_current,
	input  logic [3:0] priority_req,
	input  logic       daemon,
	output logic       done,
	output logic [3:0] slot,
	output logic [3:0] current,
	output logic       switched,
	output logic       need_resched,
	output logic       alive,
	output logic       only_daemons,
	output logic [1:0] error
);
	ctl_t ctl;
	sts_t sts;

	// command sequencer
	prq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	// tables, queues and result registers
	prq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.thread       (thread),
		.use_current  (use_current),
		.priority_req (priority_req),
		.daemon       (daemon),
		.sts          (sts),
		.done         (done),
		.slot         (slot),
		.current      (current),
		.switched     (switched),
		.need_resched (need_resched),
		.alive        (alive),
		.only_daemons (only_daemons),
		.error        (error)
	);
endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the priority run queue scheduler
module tb;
	import prq_pkg::*;

	// expected result of one command
	typedef struct {
		logic [3:0] slot;
		logic [3:0] current;
		logic       switched;
		logic       need_resched;
		logic       alive;
		logic       only_daemons;
		logic [1:0] error;
	} sched_res_t;

	// shadow scheduler state and queue of expected results
	class sched_scoreboard;
		slot_st_t   status [THREAD_SLOTS];
		int         prio [THREAD_SLOTS];
		bit         dmn [THREAD_SLOTS];
		bit         usus [THREAD_SLOTS];
		int         nxt [THREAD_SLOTS];
		int         head [PRIO_LEVELS];
		int         tail [PRIO_LEVELS];
		int         cur;
		bit         resched;
		int         live;
		int         daemons;
		sched_res_t pending [$];
		int         fails;

		function void init();
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				status[i] = ST_FREE;
				prio[i] = 0;
				dmn[i] = 0;
				usus[i] = 0;
				nxt[i] = THREAD_SLOTS;
			end
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				head[i] = THREAD_SLOTS;
				tail[i] = THREAD_SLOTS;
			end
			status[0] = ST_RUN;
			prio[0] = NORM_PRIO;
			head[NORM_PRIO] = 0;
			tail[NORM_PRIO] = 0;
			cur = 0;
			resched = 0;
			live = 1;
			daemons = 0;
			fails = 0;
		endfunction

		function void enqueue(int t);
			int p;
			p = prio[t];
			status[t] = ST_RUN;
			if (head[p] == THREAD_SLOTS) begin
				head[p] = t;
				tail[p] = t;
				if (p > prio[cur])
					resched = 1;
			end else begin
				nxt[tail[p]] = t;
				tail[p] = t;
			end
			nxt[t] = THREAD_SLOTS;
		endfunction

		function bit unlink(int t);
			int p, prv, c;
			p = prio[t];
			prv = THREAD_SLOTS;
			c = head[p];
			for (int n = 0; n < THREAD_SLOTS && c < THREAD_SLOTS; n++) begin
				if (c == t) begin
					if (prv == THREAD_SLOTS)
						head[p] = nxt[t];
					else
						nxt[prv] = nxt[t];
					if (tail[p] == t)
						tail[p] = prv;
					nxt[t] = THREAD_SLOTS;
					return 1;
				end
				prv = c;
				c = nxt[c];
			end
			return 0;
		endfunction

		function logic [1:0] pick_next();
			resched = 0;
			for (int i = PRIO_LEVELS - 1; i >= 0; i--)
				if (head[i] != THREAD_SLOTS) begin
					cur = head[i];
					return ERR_OK;
				end
			return ERR_NORUN;
		endfunction

		// note an accepted command and work out its result
		function void note_command(logic [3:0] c, logic [3:0] th, logic uc, logic [3:0] pr,
				logic dm);
			sched_res_t r;
			int tgt, was, i, p;
			bit ok;
			tgt = uc ? cur : th;
			was = cur;
			r = '{default: 0};
			ok = status[tgt] != ST_FREE;
			case (c)
				CMD_START: begin
					for (i = 0; i < THREAD_SLOTS; i++)
						if (status[i] == ST_FREE)
							break;
					if (i == THREAD_SLOTS)
						r.error = ERR_NOSLOT;
					else begin
						r.slot = 4'(i);
						prio[i] = pr;
						dmn[i] = dm;
						usus[i] = 0;
						live++;
						if (dm)
							daemons++;
						enqueue(i);
					end
				end
				CMD_RESUME:
					if (ok && status[tgt] != ST_RUN)
						enqueue(tgt);
				CMD_URESUME:
					if (ok && usus[tgt]) begin
						usus[tgt] = 0;
						if (status[tgt] != ST_RUN)
							enqueue(tgt);
					end
				CMD_USUSP:
					if (ok && status[tgt] != ST_SUSP) begin
						status[tgt] = ST_SUSP;
						usus[tgt] = 1;
						if (unlink(tgt) && tgt == cur)
							r.error = pick_next();
					end
				CMD_YIELD: begin
					p = prio[cur];
					if (status[cur] == ST_RUN && head[p] != tail[p]) begin
						if (unlink(cur))
							enqueue(cur);
						resched = 1;
					end
				end
				CMD_KILL:
					if (ok) begin
						if (status[tgt] == ST_RUN)
							void'(unlink(tgt));
						status[tgt] = ST_FREE;
						live--;
						if (dmn[tgt])
							daemons--;
						dmn[tgt] = 0;
						usus[tgt] = 0;
						nxt[tgt] = THREAD_SLOTS;
						r.only_daemons = live == daemons;
						resched = 1;
					end
				CMD_SETPRIO:
					if (ok) begin
						if (status[tgt] == ST_SUSP)
							prio[tgt] = pr;
						else begin
							void'(unlink(tgt));
							prio[tgt] = pr;
							enqueue(tgt);
						end
					end
				CMD_RESCHED: r.error = pick_next();
				CMD_QUERY: r.alive = ok;
				default: ;
			endcase
			r.current = 4'(cur);
			r.switched = cur != was;
			r.need_resched = resched;
			pending.push_back(r);
		endfunction

		function void field(string nm, int e, int a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", nm, e, a);
				fails++;
			end
		endfunction

		// compare one result with the oldest expectation
		function void check_result(sched_res_t a);
			sched_res_t e;
			if (pending.size() == 0) begin
				$error("result with no command outstanding");
				fails++;
				return;
			end
			e = pending.pop_front();
			field("slot", e.slot, a.slot);
			field("current", e.current, a.current);
			field("switched", e.switched, a.switched);
			field("need_resched", e.need_resched, a.need_resched);
			field("alive", e.alive, a.alive);
			field("only_daemons", e.only_daemons, a.only_daemons);
			field("error", e.error, a.error);
		endfunction
	endclass

	logic       clk, arst_n, start, busy, done;
	logic [3:0] cmd, thread, priority_req;
	logic       use_current, daemon;
	logic [3:0] slot, current;
	logic       switched, need_resched, alive, only_daemons;
	logic [1:0] error;

	sched_scoreboard sb;
	int  quiet_cycles;
	bit  gaps_on;

	priority_run_queue_scheduler dut (.*);

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result sampling
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{slot, current, switched, need_resched, alive, only_daemons,
				error});
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("[priority_run_queue_scheduler] ERROR");
			$finish;
		end
	end

	// issue one command and wait for it to be taken
	task automatic send(logic [3:0] c, logic [3:0] th, logic uc, logic [3:0] pr, logic dm);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start <= 1;
		cmd <= c;
		thread <= th;
		use_current <= uc;
		priority_req <= pr;
		daemon <= dm;
		do @(posedge clk); while (busy);
		sb.note_command(c, th, uc, pr, dm);
		@(negedge clk);
	endtask

	task automatic send_random();
		int k;
		k = $urandom_range(0, 99);
		send(k < 90 ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15)),
			4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
			4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// stimulus
	initial begin
		sb = new();
		sb.init();
		quiet_cycles = 0;
		gaps_on = 0;
		arst_n = 0;
		start = 0;
		cmd = CMD_QUERY;
		thread = 0;
		use_current = 0;
		priority_req = 0;
		daemon = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: every command and the corner cases
		send(CMD_QUERY, 0, 0, 0, 0);
		send(CMD_QUERY, 15, 0, 0, 0);
		send(CMD_START, 0, 0, 15, 1);
		send(CMD_START, 0, 0, 0, 0);
		send(CMD_START, 0, 0, 5, 0);
		send(CMD_YIELD, 0, 0, 0, 0);
		send(CMD_RESCHED, 0, 0, 0, 0);
		send(CMD_RESUME, 1, 0, 0, 0);
		send(CMD_USUSP, 0, 1, 0, 0);
		send(CMD_URESUME, 1, 0, 0, 0);
		send(CMD_SETPRIO, 2, 0, 15, 0);
		send(CMD_SETPRIO, 9, 0, 3, 0);
		send(CMD_KILL, 0, 1, 0, 0);
		send(CMD_KILL, 9, 0, 0, 0);
		send(CMD_RESCHED, 0, 0, 0, 0);
		for (int i = 0; i < 15; i++)
			send(CMD_START, 0, 0, 4'(i), i[0]);
		send(CMD_START, 0, 0, 7, 0);
		for (int i = 0; i < 16; i++)
			send(CMD_USUSP, 4'(i), 0, 0, 0);
		send(CMD_RESCHED, 0, 0, 0, 0);
		send(4'd12, 0, 0, 0, 0);
		for (int i = 0; i < 16; i++)
			send(CMD_KILL, 4'(i), 0, 0, 0);
		send(CMD_KILL, 0, 1, 0, 0);
		send(CMD_RESCHED, 0, 0, 0, 0);
		drain();

		// random with sender gaps
		gaps_on = 1;
		for (int i = 0; i < 380; i++) begin
			send_random();
			if (i == 200)
				drain();
		end
		// final stretch with no gaps
		gaps_on = 0;
		for (int i = 0; i < 100; i++)
			send_random();
		drain();

		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("[priority_run_queue_scheduler] OK");
		else
			$display("[priority_run_queue_scheduler] ERROR");
		$finish;
	end
endmodule
